@@ hdl/ctv_pkg.sv @@
package ctv_pkg;

	localparam logic [31:0] CrcPoly    = 32'hEDB88320;
	localparam logic [31:0] CrcAllOnes = 32'hFFFFFFFF;
	localparam int          TrailerLen = 4;
	localparam logic [2:0]  TrailerCnt = 3'(TrailerLen);

	typedef logic [7:0] byte_t;

	// One verdict for a finished image.
	typedef struct packed {
		logic        ok;
		logic        too_short;
		logic [31:0] computed;
		logic [31:0] received;
	} ctv_result_t;

	// Reflected CRC-32 update with one byte, one bit per step.
	function automatic logic [31:0] crc_feed_byte(input logic [31:0] acc, input byte_t b);
		logic [31:0] c;
		c = acc ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ hdl/ctv_tracker.sv @@
// Holds the CRC accumulator, the trailer delay line and the byte count, and
// forms the verdict for a final byte from the current state and that byte.
module ctv_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  ctv_pkg::byte_t       image_byte,
	input  logic                 final_byte,
	output ctv_pkg::ctv_result_t result
);

	logic [31:0]    crc_q;
	ctv_pkg::byte_t win_q [ctv_pkg::TrailerLen];
	logic [2:0]     count_q;

	logic [31:0] crc_next;
	logic [2:0]  count_next;
	logic        short_img;

	// The oldest byte enters the CRC only once the delay line is full.
	assign crc_next   = (count_q == ctv_pkg::TrailerCnt)
		? ctv_pkg::crc_feed_byte(crc_q, win_q[0]) : crc_q;
	assign count_next = (count_q == ctv_pkg::TrailerCnt) ? count_q : count_q + 3'd1;
	assign short_img  = (count_next != ctv_pkg::TrailerCnt);

	always_comb begin
		result.too_short = short_img;
		result.computed  = ~crc_next;
		result.received  = short_img ? 32'h00000000
			: {image_byte, win_q[3], win_q[2], win_q[1]};
		result.ok        = !short_img && (result.computed == result.received);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= ctv_pkg::CrcAllOnes;
			count_q <= 3'd0;
			for (int i = 0; i < ctv_pkg::TrailerLen; i++) begin
				win_q[i] <= 8'h00;
			end
		end else if (step) begin
			if (final_byte) begin
				crc_q   <= ctv_pkg::CrcAllOnes;
				count_q <= 3'd0;
				for (int i = 0; i < ctv_pkg::TrailerLen; i++) begin
					win_q[i] <= 8'h00;
				end
			end else begin
				crc_q   <= crc_next;
				count_q <= count_next;
				for (int i = 0; i < ctv_pkg::TrailerLen - 1; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[ctv_pkg::TrailerLen - 1] <= image_byte;
			end
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ctv_pkg::TrailerCnt)
		else $error("byte count ran past the trailer length");

	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && final_byte |=> count_q == 3'd0 && crc_q == ctv_pkg::CrcAllOnes)
		else $error("state did not restart after a final byte");

endmodule

@@ hdl/ctv_result_reg.sv @@
// Result register of the output channel; it takes a new verdict whenever
// it is empty or its current one is taken in the same cycle.
module ctv_result_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  ctv_pkg::ctv_result_t result,
	input  logic                 out_stall,
	output logic                 free,
	output logic                 out_valid,
	output ctv_pkg::ctv_result_t result_q
);

	logic valid_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			result_q <= result;
		end
	end

	a_short_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_q.too_short |->
			!result_q.ok && result_q.received == 32'h0 && result_q.computed == 32'h0)
		else $error("short image verdict carries a CRC or a pass");

	a_ok_matches: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_q.ok |-> result_q.computed == result_q.received)
		else $error("pass reported with unequal CRCs");

endmodule

@@ hdl/crc32_trailer_image_verifier.sv @@
// Channel | Handshake           | Payload
// --------+---------------------+---------------------------------------------
// in      | in_valid, in_stall  | image_byte, final_byte
// out     | out_valid, out_stall| image_ok, image_too_short, crc_computed,
//         |                     | crc_received
//
// A byte request is held in an input register, then updates the CRC state; a
// final byte also loads its verdict into the result register, from which
// out_valid is registered. One byte is taken every cycle while in_stall is
// low; the byte-wide CRC update sets the clock period.
// Reset clears the CRC, the delay line, the count and both valid flags.
// in_stall rises only when a final byte waits for an occupied, stalled
// result register; non-final bytes never wait.
module crc32_trailer_image_verifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  image_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        image_ok,
	output logic        image_too_short,
	output logic [31:0] crc_computed,
	output logic [31:0] crc_received
);

	// Input register stage.
	logic           valid_s1;
	ctv_pkg::byte_t byte_s1;
	logic           final_s1;

	ctv_pkg::ctv_result_t verdict;
	ctv_pkg::ctv_result_t verdict_q;
	logic                 res_free;
	logic                 step_s1;

	// A registered byte moves on at once unless it is a final byte whose
	// verdict has nowhere to go yet.
	assign step_s1  = valid_s1 && (!final_s1 || res_free);
	assign in_stall = valid_s1 && !step_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1  <= image_byte;
			final_s1 <= final_byte;
		end
	end

	ctv_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step_s1),
		.image_byte (byte_s1),
		.final_byte (final_s1),
		.result     (verdict)
	);

	ctv_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step_s1 && final_s1),
		.result    (verdict),
		.out_stall (out_stall),
		.free      (res_free),
		.out_valid (out_valid),
		.result_q  (verdict_q)
	);

	assign image_ok        = verdict_q.ok;
	assign image_too_short = verdict_q.too_short;
	assign crc_computed    = verdict_q.computed;
	assign crc_received    = verdict_q.received;

endmodule

@@ verif/crc32_trailer_image_checker.sv @@
module crc32_trailer_image_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  image_byte,
	input  logic        final_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        image_ok,
	input  logic        image_too_short,
	input  logic [31:0] crc_computed,
	input  logic [31:0] crc_received,
	output int          mismatches,
	output int          outstanding,
	output int          good_images,
	output int          bad_images,
	output int          short_images
);

	timeunit 1ns;
	timeprecision 1ps;

	// Shadow of the image state: running CRC, four-byte lag line, fill count.
	logic [31:0]    crc_run = ctv_pkg::CrcAllOnes;
	ctv_pkg::byte_t lag_line [ctv_pkg::TrailerLen];
	logic [2:0]     fill = '0;

	ctv_pkg::ctv_result_t verdict_q [$];

	function automatic logic [31:0] crc_advance(input logic [31:0] c,
	                                            input ctv_pkg::byte_t b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ ctv_pkg::CrcPoly;
			end
		end
		return c;
	endfunction

	function automatic void clear_image();
		crc_run = ctv_pkg::CrcAllOnes;
		for (int i = 0; i < ctv_pkg::TrailerLen; i++) begin
			lag_line[i] = '0;
		end
		fill = '0;
	endfunction

	// A byte reaches the CRC only once four newer bytes have arrived.
	function automatic void absorb_byte(input ctv_pkg::byte_t b, input logic fin);
		ctv_pkg::ctv_result_t v;
		if (fill == ctv_pkg::TrailerCnt) begin
			crc_run = crc_advance(crc_run, lag_line[0]);
		end
		for (int i = 0; i < ctv_pkg::TrailerLen - 1; i++) begin
			lag_line[i] = lag_line[i + 1];
		end
		lag_line[ctv_pkg::TrailerLen - 1] = b;
		if (fill != ctv_pkg::TrailerCnt) begin
			fill = fill + 3'd1;
		end
		if (fin) begin
			v.too_short = (fill != ctv_pkg::TrailerCnt);
			v.computed  = ~crc_run;
			v.received  = v.too_short ? 32'h0 :
			              {lag_line[3], lag_line[2], lag_line[1], lag_line[0]};
			v.ok        = !v.too_short && (v.computed == v.received);
			verdict_q.push_back(v);
			clear_image();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ctv_pkg::ctv_result_t want;
		if (!arst_n) begin
			clear_image();
			verdict_q.delete();
			mismatches   = 0;
			outstanding  = 0;
			good_images  = 0;
			bad_images   = 0;
			short_images = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("Verdict arrived with no image waiting for one.");
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					if (image_ok !== want.ok) begin
						$error("image_ok: expected %0d, got %0d", want.ok, image_ok);
						mismatches++;
					end
					if (image_too_short !== want.too_short) begin
						$error("image_too_short: expected %0d, got %0d",
						       want.too_short, image_too_short);
						mismatches++;
					end
					if (crc_computed !== want.computed) begin
						$error("crc_computed: expected %08h, got %08h",
						       want.computed, crc_computed);
						mismatches++;
					end
					if (crc_received !== want.received) begin
						$error("crc_received: expected %08h, got %08h",
						       want.received, crc_received);
						mismatches++;
					end
					if (want.too_short) begin
						short_images++;
					end else if (want.ok) begin
						good_images++;
					end else begin
						bad_images++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				absorb_byte(image_byte, final_byte);
			end
			outstanding = verdict_q.size();
		end
	end

endmodule

@@ verif/tb_crc32_trailer_image_verifier.sv @@
module tb_crc32_trailer_image_verifier;

	timeunit 1ns;
	timeprecision 1ps;

	// The run stops on its own well before this; the limit only catches a hang.
	localparam int CycleLimit  = 200000;
	localparam int ByteTarget  = 1600;

	// Receiver behavior, changed at random intervals so that stalls land
	// on every phase of the result register.
	typedef enum logic [1:0] {
		StallNever,
		StallLight,
		StallHeavy,
		StallPeriodic
	} stall_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  image_byte = '0;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        image_ok;
	logic        image_too_short;
	logic [31:0] crc_computed;
	logic [31:0] crc_received;

	int mismatches;
	int outstanding;
	int good_images;
	int bad_images;
	int short_images;

	int          cycle_count = 0;
	int          bytes_sent = 0;
	int          burst_left = 0;
	stall_mode_e stall_mode = StallNever;
	int          stall_mode_left = 0;

	// The image being assembled for the next transfer.
	ctv_pkg::byte_t image_q [$];

	crc32_trailer_image_verifier dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.image_byte     (image_byte),
		.final_byte     (final_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.image_ok       (image_ok),
		.image_too_short(image_too_short),
		.crc_computed   (crc_computed),
		.crc_received   (crc_received)
	);

	crc32_trailer_image_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.image_byte     (image_byte),
		.final_byte     (final_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.image_ok       (image_ok),
		.image_too_short(image_too_short),
		.crc_computed   (crc_computed),
		.crc_received   (crc_received),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.good_images    (good_images),
		.bad_images     (bad_images),
		.short_images   (short_images)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Watchdog: a hang anywhere in the flow ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver holds a mode for a random stretch, then picks a new one.
	// One of the modes never stalls, so some stretches run at full rate.
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode      <= stall_mode_e'($urandom_range(0, 3));
			stall_mode_left <= $urandom_range(50, 300);
		end else begin
			stall_mode_left <= stall_mode_left - 1;
		end
		case (stall_mode)
			StallNever: begin
				out_stall <= 1'b0;
			end
			StallLight: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			StallHeavy: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				out_stall <= ((cycle_count % 5) < 2);
			end
		endcase
	end

	// Reflected CRC-32 over the image assembled so far, used to build a
	// trailer that matches its payload.
	function automatic logic [31:0] payload_crc();
		logic [31:0] c;
		c = ctv_pkg::CrcAllOnes;
		foreach (image_q[i]) begin
			c = c ^ {24'h0, image_q[i]};
			repeat (8) begin
				c = (c >> 1) ^ (c[0] ? ctv_pkg::CrcPoly : 32'h0);
			end
		end
		return ~c;
	endfunction

	// The trailer goes out least significant byte first.
	task automatic append_trailer();
		logic [31:0] c;
		c = payload_crc();
		for (int i = 0; i < 4; i++) begin
			image_q.push_back(c[8*i +: 8]);
		end
	endtask

	// Mostly random bytes, with the two extremes showing up often.
	function automatic ctv_pkg::byte_t pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return ctv_pkg::byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	// One byte request. Valid stays high across a burst, so the next request
	// simply replaces the payload in the step that accepted this one. When the
	// burst runs out, valid drops for a random gap, or not at all, before the next request.
	task automatic push_byte(input ctv_pkg::byte_t b, input logic fin);
		int gap;
		in_valid   <= 1'b1;
		image_byte <= b;
		final_byte <= fin;
		do begin
			@(posedge clk);
		end while (in_stall);
		bytes_sent++;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Sends the assembled image with the final mark on its last byte.
	task automatic send_image();
		foreach (image_q[i]) begin
			push_byte(image_q[i], i == image_q.size() - 1);
		end
		image_q.delete();
	endtask

	initial begin
		int kind;
		int len;
		int flip_at;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed images. The three shortest are all too short to carry a
		// trailer, which must give a zero CRC pair and a too-short verdict.
		image_q = '{8'hFF};
		send_image();
		image_q = '{8'h00, 8'hFF};
		send_image();
		image_q = '{8'hA5, 8'h5A, 8'hFF};
		send_image();
		// Trailer with no payload: the CRC covers nothing and reads zero, so an
		// all-zero trailer passes and an all-ones trailer fails.
		image_q = '{8'h00, 8'h00, 8'h00, 8'h00};
		send_image();
		image_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_image();
		// A short payload with both byte extremes and a matching trailer.
		image_q = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h5A};
		append_trailer();
		send_image();

		// Random images. Most are well formed, so the trailer compare passes and
		// the CRC path is exercised over many lengths; a share are corrupted by
		// one bit anywhere, and the rest are short or arbitrary tails.
		while (bytes_sent < ByteTarget) begin
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
				                                   : $urandom_range(0, 16);
				repeat (len) image_q.push_back(pick_byte());
				append_trailer();
				if (kind >= 70) begin
					flip_at = $urandom_range(0, image_q.size() - 1);
					image_q[flip_at][$urandom_range(0, 7)] ^= 1'b1;
				end
			end else begin
				len = $urandom_range(1, 6);
				repeat (len) image_q.push_back(pick_byte());
			end
			send_image();
		end

		// The last accepted request may have left valid high; drop it now.
		in_valid <= 1'b0;

		// Wait for every verdict, then keep the clock running so that a stray
		// extra result from the block would still be seen.
		@(negedge clk);
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (8) @(posedge clk);

		$display("Sent %0d image bytes; verdicts seen: %0d matching, %0d mismatched CRC,",
		         bytes_sent, good_images, bad_images);
		$display("%0d too short, with %0d field mismatches.", short_images, mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
